// ----- src/spps_pkg.sv -----
// Shared constants and tables for the spiral pattern pixel shader.
package spps_pkg;

    localparam int CORDIC_STEPS = 24;
    localparam int TURN_BITS    = 32;

    localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    localparam logic [31:0] DEFAULT_COLORS [8] = '{
        32'hff6179ff, 32'hffffffff, 32'hc22485ff, 32'h94009bff,
        32'hf99dffff, 32'hc65fffff, 32'hffda9eff, 32'h80ffe6ff
    };

    localparam logic [2:0] REG_CENTER_X    = 3'd0;
    localparam logic [2:0] REG_CENTER_Y    = 3'd1;
    localparam logic [2:0] REG_SPIRAL_RATE = 3'd2;
    localparam logic [2:0] REG_ROTATION    = 3'd3;
    localparam logic [2:0] REG_ARM_COUNT   = 3'd4;
    localparam logic [2:0] REG_COLOR_COUNT = 3'd5;
    localparam logic [2:0] REG_THICKNESS   = 3'd6;
    localparam logic [2:0] REG_BACKGROUND  = 3'd7;

    localparam logic KIND_SHADE   = 1'b0;
    localparam logic KIND_PALETTE = 1'b1;

endpackage

// ----- src/spps_delay.sv -----
// Enabled shift line that keeps side data aligned with the pipelines.
module spps_delay import spps_pkg::*; #(
    parameter int W     = 1,
    parameter int DEPTH = 1
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_en,
    input  logic [W-1:0] i_data,
    output logic [W-1:0] o_data
);
    generate
        if (DEPTH == 0) begin : g_none
            assign o_data = i_data;
        end else begin : g_line
            logic [W-1:0] r_line [DEPTH];
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    for (int k = 0; k < DEPTH; k++) r_line[k] <= '0;
                end else if (i_en) begin
                    r_line[0] <= i_data;
                    for (int k = 1; k < DEPTH; k++) r_line[k] <= r_line[k-1];
                end
            end
            assign o_data = r_line[DEPTH-1];
        end
    endgenerate
endmodule

// ----- src/spps_sqrt.sv -----
// Pipelined digit-by-digit integer square root, one result bit per stage.
module spps_sqrt import spps_pkg::*; #(
    parameter int DW = 23
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [2*DW-1:0] i_rad,
    output logic [DW-1:0] o_root
);
    localparam int RMW = DW + 3;

    logic [RMW-1:0]  r_rem [DW];
    logic [DW-1:0]   r_q   [DW];
    logic [2*DW-1:0] r_v   [DW];

    genvar k;
    generate
        for (k = 0; k < DW; k++) begin : g_step
            logic [RMW-1:0]  rem_in, t, n_rem;
            logic [DW-1:0]   q_in, n_q;
            logic [2*DW-1:0] v_in;
            if (k == 0) begin : g_first
                assign rem_in = '0;
                assign q_in   = '0;
                assign v_in   = i_rad;
            end else begin : g_next
                assign rem_in = r_rem[k-1];
                assign q_in   = r_q[k-1];
                assign v_in   = r_v[k-1];
            end
            always_comb begin
                logic [RMW-1:0] cur;
                cur = {rem_in[RMW-3:0], v_in[2*DW-1 -: 2]};
                t   = RMW'({q_in, 2'b01});
                if (cur >= t) begin
                    n_rem = cur - t;
                    n_q   = {q_in[DW-2:0], 1'b1};
                end else begin
                    n_rem = cur;
                    n_q   = {q_in[DW-2:0], 1'b0};
                end
            end
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= n_rem;
                    r_q[k]   <= n_q;
                    r_v[k]   <= {v_in[2*DW-3:0], 2'b00};
                end
            end
        end
    endgenerate

    assign o_root = r_q[DW-1];
endmodule

// ----- src/spps_cordic.sv -----
// Pipelined CORDIC vectoring unit giving atan2 in 2^32 units per turn.
module spps_cordic import spps_pkg::*; #(
    parameter int IW = 15
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [IW-1:0] i_dx,
    input  logic signed [IW-1:0] i_dy,
    output logic [TURN_BITS-1:0] o_turn
);
    localparam int XW = IW + 22;

    logic signed [XW-1:0]  r_x [CORDIC_STEPS+1];
    logic signed [XW-1:0]  r_y [CORDIC_STEPS+1];
    logic [TURN_BITS-1:0]  r_z [CORDIC_STEPS+1];
    logic                  r_zero [CORDIC_STEPS+1];

    // Prescale and fold the left half plane onto the right.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_dx < 0) begin
                r_x[0] <= -(XW'(i_dx) <<< 20);
                r_y[0] <= -(XW'(i_dy) <<< 20);
                r_z[0] <= 32'h80000000;
            end else begin
                r_x[0] <= XW'(i_dx) <<< 20;
                r_y[0] <= XW'(i_dy) <<< 20;
                r_z[0] <= '0;
            end
            r_zero[0] <= (i_dx == 0) && (i_dy == 0);
        end
    end

    genvar i;
    generate
        for (i = 0; i < CORDIC_STEPS; i++) begin : g_iter
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    if (r_y[i] > 0) begin
                        r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                        r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                        r_z[i+1] <= r_z[i] + ATAN_TURNS[i];
                    end else begin
                        r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                        r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                        r_z[i+1] <= r_z[i] - ATAN_TURNS[i];
                    end
                    r_zero[i+1] <= r_zero[i];
                end
            end
        end
    endgenerate

    assign o_turn = r_zero[CORDIC_STEPS] ? '0 : r_z[CORDIC_STEPS];
endmodule

// ----- src/spiral_pattern_pixel_shader.sv -----
// Spiral pattern pixel shader: pipelined per-pixel spiral color generator.
//
// Takes one transfer per clock while the pipeline advances: a shade item
// (kind 0) gives one RGBA result, a palette item (kind 1) loads one palette
// entry and gives none. The CORDIC angle pipeline and the bit-per-stage
// square root run side by side, the shorter one padded to match; a new
// item enters every cycle unless the output holds the pipeline back.
// Palette writes travel the same pipeline and land in the palette at the
// stage where pixels read it, so ordering between writes and shades holds.
// The whole pipeline advances when the output register is empty or taken,
// so a waiting result holds back the pipeline, not the result.
// Registers sit on an APB port at byte address 8*index with 64-bit data.
module spiral_pattern_pixel_shader import spps_pkg::*; #(
    parameter int COORD_BITS    = 14,
    parameter int ANGLE_BITS    = 16,
    parameter int PALETTE_DEPTH = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input channel
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_kind,
    input  logic [COORD_BITS-1:0] i_pixel_x,
    input  logic [COORD_BITS-1:0] i_pixel_y,
    input  logic [2:0]            i_palette_slot,
    input  logic [31:0]           i_palette_color,
    // output channel
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [7:0]            o_red,
    output logic [7:0]            o_green,
    output logic [7:0]            o_blue,
    output logic [7:0]            o_alpha,
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [5:0]            paddr,
    input  logic [63:0]           pwdata,
    output logic [63:0]           prdata,
    output logic                  pready
);
    localparam int C    = COORD_BITS;
    localparam int A    = ANGLE_BITS;
    localparam int DW   = C + 9;
    localparam int RW   = 2 * C + 17;
    localparam int LCO  = CORDIC_STEPS + 1;
    localparam int LSQ  = DW + 2;
    localparam int LAT  = (LCO > LSQ) ? LCO : LSQ;
    localparam int PW   = 24 + A;
    localparam int IXW  = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
    localparam int SIDE = 1 + 1 + 3 + 32;
    localparam int RSL  = (A >= 16) ? A - 16 : 0;
    localparam int RSR  = (A >= 16) ? 0 : 16 - A;

    // ---------------- configuration registers ----------------
    logic [13:0] r_center_x, r_center_y;
    logic [33:0] r_spiral_rate;
    logic [15:0] r_rotation;
    logic [3:0]  r_arm_count, r_color_count;
    logic [7:0]  r_thickness;
    logic [31:0] r_background;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x    <= '0;
            r_center_y    <= '0;
            r_spiral_rate <= '0;
            r_rotation    <= '0;
            r_arm_count   <= 4'd4;
            r_color_count <= 4'd5;
            r_thickness   <= 8'd240;
            r_background  <= 32'h000000ff;
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[5:3])
                REG_CENTER_X:    r_center_x    <= pwdata[13:0];
                REG_CENTER_Y:    r_center_y    <= pwdata[13:0];
                REG_SPIRAL_RATE: r_spiral_rate <= pwdata[33:0];
                REG_ROTATION:    r_rotation    <= pwdata[15:0];
                REG_ARM_COUNT:   r_arm_count   <= pwdata[3:0];
                REG_COLOR_COUNT: r_color_count <= pwdata[3:0];
                REG_THICKNESS:   r_thickness   <= pwdata[7:0];
                REG_BACKGROUND:  r_background  <= pwdata[31:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[5:3])
            REG_CENTER_X:    prdata = 64'(r_center_x);
            REG_CENTER_Y:    prdata = 64'(r_center_y);
            REG_SPIRAL_RATE: prdata = 64'(r_spiral_rate);
            REG_ROTATION:    prdata = 64'(r_rotation);
            REG_ARM_COUNT:   prdata = 64'(r_arm_count);
            REG_COLOR_COUNT: prdata = 64'(r_color_count);
            REG_THICKNESS:   prdata = 64'(r_thickness);
            REG_BACKGROUND:  prdata = 64'(r_background);
            default:         prdata = '0;
        endcase
    end

    // ---------------- pipeline control ----------------
    // Advance everything when the output register is free or being taken.
    logic r_o_valid;
    logic en;
    assign en      = !r_o_valid || i_ready;
    assign o_ready = en;
    assign o_valid = r_o_valid;

    // ---------------- entry stage: offset from center ----------------
    logic              r_v0;
    logic [SIDE-2:0]   r_side0;
    logic signed [C:0] r_dx, r_dy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (en) begin
            r_v0 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side0 <= {i_kind, i_palette_slot, i_palette_color};
            r_dx    <= $signed({1'b0, i_pixel_x}) - $signed({1'b0, C'(r_center_x)});
            r_dy    <= $signed({1'b0, i_pixel_y}) - $signed({1'b0, C'(r_center_y)});
        end
    end

    // ---------------- distance: squares, sum, square root ----------------
    logic [2*C-1:0]  r_sqx, r_sqy;
    logic [RW-1:0]   r_rad;
    logic [DW-1:0]   root, radius;
    logic [31:0]     turn, turn_al;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sqx <= (2*C)'(r_dx * r_dx);
            r_sqy <= (2*C)'(r_dy * r_dy);
            r_rad <= {(RW-16)'(r_sqx) + (RW-16)'(r_sqy), 16'd0};
        end
    end

    spps_sqrt #(.DW(DW)) u_sqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_rad  ((2*DW)'(r_rad)),
        .o_root (root)
    );

    spps_cordic #(.IW(C + 1)) u_cordic (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_dx   (r_dx),
        .i_dy   (r_dy),
        .o_turn (turn)
    );

    // Pad the shorter of the two units so both land together.
    spps_delay #(.W(DW), .DEPTH(LAT - LSQ)) u_dist_pad (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (en),
        .i_data (root), .o_data (radius)
    );

    spps_delay #(.W(32), .DEPTH(LAT - LCO)) u_turn_pad (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (en),
        .i_data (turn), .o_data (turn_al)
    );

    logic [SIDE-1:0] side_al;
    spps_delay #(.W(SIDE), .DEPTH(LAT)) u_side (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (en),
        .i_data ({r_v0, r_side0}), .o_data (side_al)
    );

    // ---------------- stage M1: partial products, angle rounding ----------------
    logic [SIDE-1:0]        r_s1;
    logic [DW+16:0]         r_p_lo;
    logic signed [DW+17:0]  r_p_hi;
    logic [A-1:0]           r_ang1;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p_lo <= radius * r_spiral_rate[16:0];
            r_p_hi <= $signed({1'b0, radius}) * $signed(r_spiral_rate[33:17]);
            r_ang1 <= A'((turn_al + (32'd1 << (31 - A))) >> (32 - A));
        end
    end

    // ---------------- stage M2: combine product, take spiral term ----------------
    logic [SIDE-1:0] r_s2;
    logic [PW-1:0]   prod;
    logic [A-1:0]    r_spiral2, r_ang2;

    assign prod = PW'(r_p_lo) + (PW'(r_p_hi) << 17);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_spiral2 <= prod[24 +: A];
            r_ang2    <= r_ang1;
        end
    end

    // ---------------- stage M3: total angle ----------------
    logic [SIDE-1:0] r_s3;
    logic [A-1:0]    r_total3, rot;

    assign rot = A'((32'(r_rotation) << RSL) >> RSR);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_total3 <= r_ang2 + r_spiral2 + rot;
        end
    end

    // ---------------- stage M4: phase inside one arm ----------------
    logic [SIDE-1:0] r_s4;
    logic [A-1:0]    r_phase4;
    logic [3:0]      arms;

    assign arms = (r_arm_count == 4'd0) ? 4'd1 : r_arm_count;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_phase4 <= A'(r_total3 * arms);
        end
    end

    // ---------------- stage M5: color index and arm test ----------------
    logic [SIDE-1:0] r_s5;
    logic [IXW-1:0]  r_idx5;
    logic            r_on5;
    logic [3:0]      ncol, qcol, icol;
    logic [A+2:0]    scaled;

    always_comb begin
        if (r_color_count < 4'd2) begin
            ncol = 4'd2;
        end else if (32'(r_color_count) > PALETTE_DEPTH) begin
            ncol = 4'(PALETTE_DEPTH);
        end else begin
            ncol = r_color_count;
        end
        scaled = r_phase4 * ncol[3:0];
        qcol   = 4'(scaled >> (A - 1));
        icol   = (qcol >= ncol) ? qcol - ncol : qcol;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_idx5 <= icol[IXW-1:0];
            r_on5  <= (A+3)'(r_phase4) <= ((A+3)'(r_thickness) << (A - 5));
        end
    end

    // Valid bits and side data for stages M1..M5.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
            r_s2 <= '0;
            r_s3 <= '0;
            r_s4 <= '0;
            r_s5 <= '0;
        end else if (en) begin
            r_s1 <= side_al;
            r_s2 <= r_s1;
            r_s3 <= r_s2;
            r_s4 <= r_s3;
            r_s5 <= r_s4;
        end
    end

    // ---------------- stage M6: palette access and output ----------------
    logic        s5_valid, s5_kind;
    logic [2:0]  s5_slot;
    logic [31:0] s5_color, pick;
    logic [31:0] r_palette [PALETTE_DEPTH];
    logic [7:0]  r_red, r_green, r_blue, r_alpha;

    assign {s5_valid, s5_kind, s5_slot, s5_color} = r_s5;

    // Drop writes to slots past the store.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < PALETTE_DEPTH; k++) r_palette[k] <= DEFAULT_COLORS[k & 7];
        end else if (en && s5_valid && (s5_kind == KIND_PALETTE)
                     && (32'(s5_slot) < PALETTE_DEPTH)) begin
            r_palette[s5_slot[IXW-1:0]] <= s5_color;
        end
    end

    assign pick = r_on5 ? r_palette[r_idx5] : r_background;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (en) begin
            r_o_valid <= s5_valid && (s5_kind == KIND_SHADE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_red   <= pick[31:24];
            r_green <= pick[23:16];
            r_blue  <= pick[15:8];
            r_alpha <= r_on5 ? 8'hff : pick[7:0];
        end
    end

    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;
    assign o_alpha = r_alpha;
endmodule

// ----- verif/spps_checker.sv -----
`timescale 1ns / 1ps
// Checker for the spiral pattern pixel shader: predicts each shaded pixel and compares.
module spps_checker import spps_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        o_ready,
    input  logic        i_kind,
    input  logic [13:0] i_pixel_x,
    input  logic [13:0] i_pixel_y,
    input  logic [2:0]  i_palette_slot,
    input  logic [31:0] i_palette_color,
    input  logic        o_valid,
    input  logic        i_ready,
    input  logic [7:0]  o_red,
    input  logic [7:0]  o_green,
    input  logic [7:0]  o_blue,
    input  logic [7:0]  o_alpha,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    input  logic        pready,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_pixels_checked
);

    logic [31:0] palette [8];
    logic [13:0] cen_x, cen_y;
    longint      rate;
    logic [15:0] rot;
    logic [3:0]  arms_reg, ncol_reg;
    logic [7:0]  thick;
    logic [31:0] bg;
    logic [31:0] expected_rgba [$];

    function automatic logic [31:0] shade_rgba(input logic [13:0] px, input logic [13:0] py);
        longint          dx, dy, tx, ty, nx;
        longint unsigned sq, rad, bt;
        logic [63:0]     prod;
        logic [31:0]     z;
        logic [32:0]     zr;
        logic [15:0]     sp, ang, tot, ph;
        logic [31:0]     wide;
        int              arms, n, idx, thresh;
        logic [31:0]     col;
        dx = longint'(px) - longint'(cen_x);
        dy = longint'(py) - longint'(cen_y);
        // integer square root of the squared distance with 8 fraction bits
        sq  = longint'(dx * dx + dy * dy) << 16;
        rad = 0;
        bt  = 64'd1 << 62;
        while (bt > sq) bt = bt >> 2;
        while (bt != 0) begin
            if (sq >= rad + bt) begin
                sq  = sq - (rad + bt);
                rad = (rad >> 1) + bt;
            end else begin
                rad = rad >> 1;
            end
            bt = bt >> 2;
        end
        prod = rate * longint'(rad);
        sp   = prod[39:24];
        // vectoring CORDIC, turn accumulator 32 bits
        z = 32'd0;
        if (dx != 0 || dy != 0) begin
            tx = dx * 1048576;
            ty = dy * 1048576;
            if (tx < 0) begin
                tx = -tx;
                ty = -ty;
                z  = 32'h8000_0000;
            end
            for (int i = 0; i < CORDIC_STEPS; i++) begin
                if (ty > 0) begin
                    nx = tx + (ty >>> i);
                    ty = ty - (tx >>> i);
                    z  = z + ATAN_TURNS[i];
                end else begin
                    nx = tx - (ty >>> i);
                    ty = ty + (tx >>> i);
                    z  = z - ATAN_TURNS[i];
                end
                tx = nx;
            end
        end
        zr   = {1'b0, z} + 33'h8000;
        ang  = zr[31:16];
        tot  = ang + sp + rot;
        arms = (arms_reg == 0) ? 1 : int'(arms_reg);
        wide = tot * arms;
        ph   = wide[15:0];
        n    = int'(ncol_reg);
        if (n < 2) n = 2;
        if (n > 8) n = 8;
        idx    = ((int'(ph) * n) >> 15) % n;
        thresh = int'(thick) << 11;
        if (int'(ph) <= thresh) begin
            col = palette[idx];
            return {col[31:8], 8'hff};
        end
        return bg;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 8; i++) palette[i] <= DEFAULT_COLORS[i];
            cen_x    <= '0;
            cen_y    <= '0;
            rate     <= 0;
            rot      <= '0;
            arms_reg <= 4'd4;
            ncol_reg <= 4'd5;
            thick    <= 8'd240;
            bg       <= 32'h0000_00ff;
            expected_rgba.delete();
            o_fail_count     <= 0;
            o_pixels_checked <= 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[5:3])
                    REG_CENTER_X:    cen_x    <= pwdata[13:0];
                    REG_CENTER_Y:    cen_y    <= pwdata[13:0];
                    REG_SPIRAL_RATE: rate     <= longint'(signed'(pwdata[33:0]));
                    REG_ROTATION:    rot      <= pwdata[15:0];
                    REG_ARM_COUNT:   arms_reg <= pwdata[3:0];
                    REG_COLOR_COUNT: ncol_reg <= pwdata[3:0];
                    REG_THICKNESS:   thick    <= pwdata[7:0];
                    REG_BACKGROUND:  bg       <= pwdata[31:0];
                    default: ;
                endcase
            end
            // palette loads take effect in stream order, before the next transfer
            if (i_valid && o_ready) begin
                if (i_kind == KIND_PALETTE)
                    palette[i_palette_slot] <= i_palette_color;
                else
                    expected_rgba.push_back(shade_rgba(i_pixel_x, i_pixel_y));
            end
            if (o_valid && i_ready) begin
                o_pixels_checked <= o_pixels_checked + 1;
                if (expected_rgba.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("%0t: unexpected pixel %h%h%h%h", $realtime,
                                 o_red, o_green, o_blue, o_alpha);
                    o_fail_count <= o_fail_count + 1;
                end else if (expected_rgba[0] != {o_red, o_green, o_blue, o_alpha}) begin
                    if (o_fail_count < 10)
                        $display("%0t: pixel mismatch, expected %h got %h%h%h%h", $realtime,
                                 expected_rgba[0], o_red, o_green, o_blue, o_alpha);
                    o_fail_count <= o_fail_count + 1;
                    void'(expected_rgba.pop_front());
                end else begin
                    void'(expected_rgba.pop_front());
                end
            end
        end
    end

    assign o_pending = expected_rgba.size();

endmodule

// ----- verif/tb_spiral_pattern_pixel_shader.sv -----
`timescale 1ns / 1ps
// Top of the pixel shader testbench: clock, reset, stimulus and verdict.
module tb_spiral_pattern_pixel_shader import spps_pkg::*; ();

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES  = 60;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic        i_kind = KIND_SHADE;
    logic [13:0] i_pixel_x = '0;
    logic [13:0] i_pixel_y = '0;
    logic [2:0]  i_palette_slot = '0;
    logic [31:0] i_palette_color = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [7:0]  o_red, o_green, o_blue, o_alpha;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [5:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;

    int fail_count, pending, pixels_checked;
    int items_sent = 0;
    int idle_cycles = 0;
    int stall_left = 0;
    int stall_draw;
    bit send_gaps = 1'b1;
    bit recv_stalls = 1'b1;
    logic [13:0] cur_cx = '0, cur_cy = '0;

    always #6 i_clk = ~i_clk;

    spiral_pattern_pixel_shader u_dut (.*);

    spps_checker u_checker (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_kind, .i_pixel_x, .i_pixel_y,
        .i_palette_slot, .i_palette_color, .o_valid, .i_ready,
        .o_red, .o_green, .o_blue, .o_alpha,
        .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
        .o_fail_count(fail_count), .o_pending(pending), .o_pixels_checked(pixels_checked)
    );

    // Receiver: after each transfer draw a random stall, drop ready meanwhile.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready    <= 1'b0;
            stall_left <= 0;
        end else if (o_valid && i_ready) begin
            stall_draw = recv_stalls ? $urandom_range(0, 12) : 0;
            stall_left <= stall_draw;
            i_ready    <= (stall_draw == 0);
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            i_ready    <= (stall_left == 1);
        end else begin
            i_ready <= 1'b1;
        end
    end

    // Watchdog: count cycles with no transfer on any port.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || psel) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog expired with %0d pixels outstanding", pending);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // Setup cycle, access cycle, then the bus returns to idle.
    task automatic reg_write(input logic [2:0] idx, input logic [63:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        while (!pready) @(negedge i_clk);
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // Hold valid and payload until the transfer; returns at the accepting edge.
    task automatic send_item(input logic kind, input logic [13:0] px, input logic [13:0] py,
                             input logic [2:0] slot, input logic [31:0] color);
        int gap;
        gap = send_gaps ? $urandom_range(0, 12) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_kind          <= kind;
        i_pixel_x       <= px;
        i_pixel_y       <= py;
        i_palette_slot  <= slot;
        i_palette_color <= color;
        @(negedge i_clk);
        while (!o_ready) @(negedge i_clk);
        @(posedge i_clk);
        items_sent++;
    endtask

    task automatic shade(input logic [13:0] px, input logic [13:0] py);
        send_item(KIND_SHADE, px, py, 3'($urandom), 32'($urandom));
    endtask

    // Drop valid, let the pipeline empty, including trailing palette loads.
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic configure(input logic [13:0] cx, input logic [13:0] cy,
                             input logic [33:0] rate, input logic [15:0] rot,
                             input logic [3:0] arms, input logic [3:0] ncol,
                             input logic [7:0] thick, input logic [31:0] bg);
        reg_write(REG_CENTER_X, 64'(cx));
        reg_write(REG_CENTER_Y, 64'(cy));
        reg_write(REG_SPIRAL_RATE, 64'(rate));
        reg_write(REG_ROTATION, 64'(rot));
        reg_write(REG_ARM_COUNT, 64'(arms));
        reg_write(REG_COLOR_COUNT, 64'(ncol));
        reg_write(REG_THICKNESS, 64'(thick));
        reg_write(REG_BACKGROUND, 64'(bg));
        cur_cx = cx;
        cur_cy = cy;
    endtask

    // Half the pixels near the center where the spiral turns fast, half anywhere.
    task automatic random_items(input int count);
        logic [13:0] px, py;
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(0, 4) == 0) begin
                send_item(KIND_PALETTE, 14'($urandom), 14'($urandom), 3'($urandom),
                          32'($urandom));
            end else begin
                if ($urandom_range(0, 1) == 0) begin
                    px = cur_cx + 14'($urandom_range(0, 128)) - 14'd64;
                    py = cur_cy + 14'($urandom_range(0, 128)) - 14'd64;
                end else begin
                    px = 14'($urandom);
                    py = 14'($urandom);
                end
                shade(px, py);
            end
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part at reset settings: center, corners, unit steps, palette extremes.
        shade(14'd0, 14'd0);
        shade(14'd16383, 14'd0);
        shade(14'd0, 14'd16383);
        shade(14'd16383, 14'd16383);
        shade(14'd1, 14'd0);
        shade(14'd0, 14'd1);
        shade(14'd8191, 14'd8192);
        send_item(KIND_PALETTE, '0, '0, 3'd0, 32'h0000_0000);
        send_item(KIND_PALETTE, '1, '1, 3'd7, 32'hffff_ffff);
        shade(14'd0, 14'd0);
        shade(14'd5, 14'd2);
        shade(14'd300, 14'd40);
        shade(14'd2, 14'd9);
        drain();

        // Extremes: zero arms, colors below range, zero thickness, most negative rate.
        configure(14'd0, 14'd0, 34'h2_0000_0000, 16'hffff, 4'd0, 4'd0, 8'd0, 32'($urandom));
        random_items(65);
        drain();

        configure(14'd16383, 14'd16383, 34'h1_ffff_ffff, 16'h0000, 4'd15, 4'd15, 8'd255,
                  32'($urandom));
        shade(14'd16383, 14'd16383);
        shade(14'd0, 14'd0);
        random_items(65);
        drain();

        // Back-to-back run with no gaps or stalls.
        send_gaps   = 1'b0;
        recv_stalls = 1'b0;
        configure(14'd8192, 14'd8192, 34'h0_0004_0000, 16'($urandom), 4'd1, 4'd8, 8'd8,
                  32'($urandom));
        random_items(65);
        drain();
        send_gaps   = 1'b1;
        recv_stalls = 1'b1;

        configure(14'($urandom), 14'($urandom), 34'({$urandom, $urandom}), 16'($urandom),
                  4'($urandom_range(1, 10)), 4'($urandom_range(2, 8)),
                  8'($urandom_range(8, 240)), 32'($urandom));
        random_items(65);
        drain();

        configure(14'($urandom), 14'($urandom), -34'sd196608, 16'($urandom), 4'd10, 4'd2,
                  8'd240, 32'($urandom));
        random_items(65);
        drain();

        send_gaps = 1'b0;
        configure(14'($urandom), 14'($urandom), 34'({$urandom, $urandom}), 16'($urandom),
                  4'($urandom), 4'($urandom), 8'($urandom), 32'($urandom));
        random_items(65);
        drain();

        $display("Sent %0d items over seven register settings; %0d shaded pixels checked.",
                 items_sent, pixels_checked);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ----- files.f -----
src/spps_pkg.sv
src/spps_delay.sv
src/spps_sqrt.sv
src/spps_cordic.sv
src/spiral_pattern_pixel_shader.sv
verif/spps_checker.sv
verif/tb_spiral_pattern_pixel_shader.sv
